// File: rtl/bkle_pkg.sv
// ----------------------------------------------------------------------------
// bkle_pkg
// Shared operation codes, controller states and the command/status bundles
// between the list controller and its datapath.
// ----------------------------------------------------------------------------
package bkle_pkg;

	// Configuration register file
	localparam int CAP_BITS = 7;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic REG_CAPACITY = 1'b0;

	// Operation codes carried by func
	typedef enum logic [2:0] {
		F_INSERT = 3'd0,
		F_REMOVE = 3'd1,
		F_QUERY  = 3'd2,
		F_CLEAR  = 3'd3,
		F_FIRST  = 3'd4,
		F_NEXT   = 3'd5
	} func_t;

	// Read address source for the entry store
	typedef enum logic [1:0] {
		RS_PTR  = 2'd0,
		RS_PTR1 = 2'd1,
		RS_ZERO = 2'd2,
		RS_CURN = 2'd3
	} rsel_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_EXEC     = 3'd1,
		ST_SCAN_RD  = 3'd2,
		ST_SCAN_CMP = 3'd3,
		ST_SHIFT_RD = 3'd4,
		ST_SHIFT_WR = 3'd5,
		ST_READ_OUT = 3'd6,
		ST_DONE     = 3'd7
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic  load_in;
		logic  ptr_clr;
		logic  ptr_inc;
		logic  rd_en;
		rsel_t rd_sel;
		logic  wr_ins;
		logic  wr_shift;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  cnt_clr;
		logic  cur_clr;
		logic  cur_inc;
		logic  ok_set;
		logic  res_take;
		logic  out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		func_t func;
		logic  cnt_lt_lim;
		logic  cnt_nz;
		logic  ptr_lt_cnt;
		logic  ptr1_lt_cnt;
		logic  key_match;
		logic  curn_lt_cnt;
		logic  out_free;
	} sts_t;

endpackage

// File: rtl/bkle_ctrl.sv
// ----------------------------------------------------------------------------
// bkle_ctrl
// Sequencer for the keyed list: decodes one request, steps the scan and
// shift loops, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bkle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bkle_pkg::sts_t sts,
	output bkle_pkg::cmd_t cmd
);
	import bkle_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.rd_sel = RS_PTR;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (sts.func)
					F_INSERT: begin
						if (sts.cnt_lt_lim) begin
							cmd.wr_ins  = 1'b1;
							cmd.cnt_inc = 1'b1;
							cmd.ok_set  = 1'b1;
						end
					end
					F_REMOVE, F_QUERY: begin
						cmd.ptr_clr = 1'b1;
						state_d     = ST_SCAN_RD;
					end
					F_CLEAR: begin
						if (sts.cnt_nz) begin
							cmd.cnt_clr = 1'b1;
							cmd.ok_set  = 1'b1;
						end
					end
					F_FIRST: begin
						cmd.cur_clr = 1'b1;
						if (sts.cnt_nz) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RS_ZERO;
							state_d    = ST_READ_OUT;
						end
					end
					F_NEXT: begin
						cmd.cur_inc = 1'b1;
						if (sts.curn_lt_cnt) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RS_CURN;
							state_d    = ST_READ_OUT;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			// Fetch the next candidate, or give up past the last entry
			ST_SCAN_RD: begin
				if (sts.ptr_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RS_PTR;
					state_d    = ST_SCAN_CMP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN_CMP: begin
				if (sts.key_match) begin
					if (sts.func == F_REMOVE) begin
						cmd.ok_set = 1'b1;
						state_d    = ST_SHIFT_RD;
					end else begin
						cmd.res_take = 1'b1;
						state_d      = ST_DONE;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			// Close the gap one entry at a time
			ST_SHIFT_RD: begin
				if (sts.ptr1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RS_PTR1;
					state_d    = ST_SHIFT_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_READ_OUT: begin
				cmd.res_take = 1'b1;
				state_d      = ST_DONE;
			end
			// Wait for the output register to drain
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted request did not start execution");

	a_shift_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT_WR |=> state_q == ST_SHIFT_RD)
		else $error("shift write not followed by shift read");

	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && sts.out_free |=> state_q == ST_IDLE)
		else $error("result hand-off did not return to idle");

endmodule

// File: rtl/bkle_dp.sv
// ----------------------------------------------------------------------------
// bkle_dp
// Datapath of the keyed list: entry store, count, cursor, scan pointer,
// pending result and the output register.
// ----------------------------------------------------------------------------
module bkle_dp #(
	parameter int DEPTH      = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bkle_pkg::cmd_t                cmd,
	output bkle_pkg::sts_t                sts,
	input  logic [bkle_pkg::CAP_BITS-1:0] capacity,
	input  logic [2:0]                    func,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          ok,
	output logic [KEY_BITS-1:0]           found_key,
	output logic [VALUE_BITS-1:0]         found_value
);
	import bkle_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;
	localparam int EW = KEY_BITS + VALUE_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	logic [EW-1:0]         mem [DEPTH];
	logic [EW-1:0]         rdata_q;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [EW-1:0]         wdata;
	logic                  we;

	func_t                 func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cur_q;
	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         curn;
	logic [CW:0]           ptr1;
	logic [LW-1:0]         cap_l;
	logic [LW-1:0]         limit;
	logic                  ok_q;
	logic [KEY_BITS-1:0]   fk_q;
	logic [VALUE_BITS-1:0] fv_q;
	logic                  out_valid_q;
	logic                  ok_out_q;
	logic [KEY_BITS-1:0]   fk_out_q;
	logic [VALUE_BITS-1:0] fv_out_q;

	// Derived pointers and limit
	always_comb begin
		curn  = (cur_q < DEPTH_C) ? cur_q + CW'(1) : cur_q;
		ptr1  = {1'b0, ptr_q} + (CW+1)'(1);
		cap_l = LW'(capacity);
		limit = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
	end

	// Store addressing
	always_comb begin
		case (cmd.rd_sel)
			RS_PTR:  raddr = ptr_q[AW-1:0];
			RS_PTR1: raddr = ptr1[AW-1:0];
			RS_ZERO: raddr = '0;
			RS_CURN: raddr = curn[AW-1:0];
			default: raddr = '0;
		endcase
		we    = cmd.wr_ins | cmd.wr_shift;
		waddr = cmd.wr_ins ? cnt_q[AW-1:0] : ptr_q[AW-1:0];
		wdata = cmd.wr_ins ? {key_q, val_q} : rdata_q;
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func_t'(func);
			key_q  <= key;
			val_q  <= value;
		end
	end

	// Count, cursor and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cur_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.cur_clr) begin
				cur_q <= '0;
			end else if (cmd.cur_inc) begin
				cur_q <= curn;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ok_q <= 1'b0;
			fk_q <= '0;
			fv_q <= '0;
		end else if (cmd.res_take) begin
			ok_q <= 1'b1;
			fk_q <= rdata_q[EW-1 -: KEY_BITS];
			fv_q <= rdata_q[VALUE_BITS-1:0];
		end else if (cmd.ok_set) begin
			ok_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ok_out_q <= ok_q;
			fk_out_q <= fk_q;
			fv_out_q <= fv_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_out_q;
	assign found_key   = fk_out_q;
	assign found_value = fv_out_q;

	// Status back to the controller
	always_comb begin
		sts.func        = func_q;
		sts.cnt_lt_lim  = LW'(cnt_q) < limit;
		sts.cnt_nz      = cnt_q != '0;
		sts.ptr_lt_cnt  = ptr_q < cnt_q;
		sts.ptr1_lt_cnt = ptr1 < {1'b0, cnt_q};
		sts.key_match   = rdata_q[EW-1 -: KEY_BITS] == key_q;
		sts.curn_lt_cnt = curn < cnt_q;
		sts.out_free    = !out_valid_q || out_ready;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C && cur_q <= DEPTH_C)
		else $error("count or cursor beyond store depth");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_ins |-> cnt_q < DEPTH_C)
		else $error("insert into a full store");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> ptr1 < {1'b0, cnt_q})
		else $error("shift write outside the live entries");

endmodule

// File: rtl/bounded_keyed_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_keyed_list_engine
// Bounded key/value list with linear search: insert, remove, query, clear,
// first and next, plus a capacity register on an APB-style port.
// ----------------------------------------------------------------------------
// Accept, execute, then done, which loads the output register once it is free;
// a first or next that reads an entry adds a read-out state. Query and remove
// scan from the head to the first hit; remove then shifts later entries down.
// Scan and gap shift each take a read and a compare or write step per entry.
// One request at a time: the next is taken in the cycle after the result is
// loaded, while it waits. Reset clears count, cursor, capacity 64.
module bounded_keyed_list_engine #(
	parameter int DEPTH      = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      func,
	input  logic [KEY_BITS-1:0]             key,
	input  logic [VALUE_BITS-1:0]           value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [KEY_BITS-1:0]             found_key,
	output logic [VALUE_BITS-1:0]           found_value,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bkle_pkg::PADDR_BITS-1:0] paddr,
	input  logic [bkle_pkg::PDATA_BITS-1:0] pwdata,
	output logic [bkle_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready
);
	import bkle_pkg::*;

	logic [CAP_BITS-1:0] capacity_q;
	cmd_t                cmd;
	sts_t                sts;

	// Capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_BITS-1:0];
		end
	end

	// Register read
	always_comb begin
		pready = 1'b1;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = PDATA_BITS'(capacity_q);
		end else begin
			prdata = '0;
		end
	end

	bkle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bkle_dp #(
		.DEPTH      (DEPTH),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.capacity    (capacity_q),
		.func        (func),
		.key         (key),
		.value       (value),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.ok          (ok),
		.found_key   (found_key),
		.found_value (found_value)
	);

endmodule

// File: tb/sv/tb_bounded_keyed_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_keyed_list_engine
// Self-checking bench for the keyed list engine. Requests go in with random
// gaps while the response side stalls at random. A behavioral mirror of the
// list predicts every response, and each field is compared as it leaves.
// ----------------------------------------------------------------------------
module tb_bounded_keyed_list_engine;
	import bkle_pkg::*;

	localparam int DEPTH         = 64;
	localparam int KEY_W         = 32;
	localparam int VAL_W         = 32;
	localparam int POOL_SIZE     = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [2:0] F_RSVD6 = 3'd6;
	localparam logic [2:0] F_RSVD7 = 3'd7;
	localparam logic [PADDR_BITS-1:0] CAP_ADDR = PADDR_BITS'(4 * int'(REG_CAPACITY));

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] fkey;
		logic [VAL_W-1:0] fval;
	} list_outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [2:0]            func;
	logic [KEY_W-1:0]      key;
	logic [VAL_W-1:0]      value;
	logic                  out_valid;
	logic                  out_ready;
	logic                  ok;
	logic [KEY_W-1:0]      found_key;
	logic [VAL_W-1:0]      found_value;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// Mirror of the list contents, cursor and capacity
	logic [KEY_W-1:0]    key_mirror [DEPTH];
	logic [VAL_W-1:0]    value_mirror [DEPTH];
	int                  mirror_count;
	int                  mirror_cursor;
	logic [CAP_BITS-1:0] mirror_capacity;

	list_outcome_t    outcome_q [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               error_count;
	logic             no_idle;
	logic             hold_req;

	bounded_keyed_list_engine u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.found_key   (found_key),
		.found_value (found_value),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the mirror and return the response it must produce
	function automatic list_outcome_t mirror_apply(logic [2:0] op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		list_outcome_t res;
		int lim;
		int pos;
		res = '0;
		lim = (mirror_capacity > DEPTH) ? DEPTH : int'(mirror_capacity);
		pos = -1;
		// first matching entry, searched from the head
		for (int i = 0; i < mirror_count; i++) begin
			if (pos < 0 && key_mirror[i] == k) pos = i;
		end
		case (op)
			F_INSERT: begin
				if (mirror_count < lim) begin
					key_mirror[mirror_count] = k;
					value_mirror[mirror_count] = v;
					mirror_count++;
					res.ok = 1'b1;
				end
			end
			F_REMOVE: begin
				if (pos >= 0) begin
					// close the gap, cursor untouched
					for (int j = pos; j + 1 < mirror_count; j++) begin
						key_mirror[j] = key_mirror[j + 1];
						value_mirror[j] = value_mirror[j + 1];
					end
					mirror_count--;
					res.ok = 1'b1;
				end
			end
			F_QUERY: begin
				if (pos >= 0) res = '{1'b1, key_mirror[pos], value_mirror[pos]};
			end
			F_CLEAR: begin
				if (mirror_count > 0) begin
					mirror_count = 0;
					res.ok = 1'b1;
				end
			end
			F_FIRST: begin
				mirror_cursor = 0;
				if (mirror_count > 0) res = '{1'b1, key_mirror[0], value_mirror[0]};
			end
			F_NEXT: begin
				// saturate at the store depth so the cursor never wraps
				if (mirror_cursor < DEPTH) mirror_cursor++;
				if (mirror_cursor < mirror_count)
					res = '{1'b1, key_mirror[mirror_cursor], value_mirror[mirror_cursor]};
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Mostly keys from a small pool so remove and query hit, sometimes any key
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_func(int ins_pct, int clr_pct);
		int r;
		r = $urandom_range(99);
		if (r < ins_pct) return F_INSERT;
		if (r < ins_pct + clr_pct) return F_CLEAR;
		r = $urandom_range(99);
		if (r < 35) return F_REMOVE;
		if (r < 65) return F_QUERY;
		if (r < 75) return F_FIRST;
		if (r < 97) return F_NEXT;
		return r[0] ? F_RSVD6 : F_RSVD7;
	endfunction

	// Offer one request, hold it until accepted, then record its outcome
	task automatic send_request(input logic [2:0] op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		if (!no_idle && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 32);
		end
		in_valid <= 1'b1;
		func <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		outcome_q.push_back(mirror_apply(op, k, v));
	endtask

	// Drain outstanding responses, write capacity, read it back
	task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
		in_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= PDATA_BITS'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		mirror_capacity = cap;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== PDATA_BITS'(cap)) begin
			$error("capacity readback mismatch: expected %0d, got %0d", cap, prdata);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(input int n, input int ins_pct, input int clr_pct);
		for (int i = 0; i < n; i++)
			send_request(pick_func(ins_pct, clr_pct), pick_key(), $urandom);
	endtask

	// Empty-list behavior, extremes of key and value, duplicates, every code
	task automatic test_directed();
		send_request(F_FIRST, '0, '0);
		send_request(F_NEXT, '0, '0);
		send_request(F_CLEAR, '0, '0);
		send_request(F_QUERY, '0, '0);
		send_request(F_REMOVE, '1, '0);
		send_request(F_INSERT, '0, '0);
		send_request(F_INSERT, '1, '1);
		send_request(F_INSERT, '0, 32'h5A5A_A5A5);
		send_request(F_INSERT, 32'h1234_5678, 32'h8765_4321);
		send_request(F_QUERY, '0, '1);
		send_request(F_QUERY, '1, '0);
		send_request(F_QUERY, 32'hDEAD_BEEF, '0);
		send_request(F_FIRST, '0, '0);
		repeat (4) send_request(F_NEXT, '0, '0);
		// removing the first duplicate exposes the second one
		send_request(F_REMOVE, '0, '0);
		send_request(F_QUERY, '0, '0);
		send_request(F_REMOVE, 32'h1234_5678, '0);
		send_request(F_REMOVE, 32'hDEAD_BEEF, '0);
		send_request(F_RSVD6, '1, '1);
		send_request(F_RSVD7, '1, '1);
		send_request(F_CLEAR, '0, '0);
		send_request(F_CLEAR, '0, '0);
	endtask

	// No room at all: every insert is refused
	task automatic test_capacity_zero();
		write_capacity('0);
		run_random(40, 50, 2);
	endtask

	task automatic test_capacity_one();
		write_capacity(7'd1);
		run_random(80, 40, 5);
	endtask

	// Capacity above depth: fill the store, overflow once, walk past the end
	task automatic test_full_list_walk();
		write_capacity('1);
		send_request(F_CLEAR, '0, '0);
		repeat (DEPTH + 1) send_request(F_INSERT, pick_key(), $urandom);
		send_request(F_FIRST, '0, '0);
		repeat (DEPTH + 6) send_request(F_NEXT, $urandom, $urandom);
	endtask

	// Both sides always ready for a long stretch
	task automatic test_no_idle_stretch();
		no_idle = 1'b1;
		run_random(300, 40, 2);
		no_idle = 1'b0;
	endtask

	// Lower capacity below the count: entries stay, inserts fail while the count is at or above it
	task automatic test_capacity_shrink();
		write_capacity(7'd64);
		send_request(F_CLEAR, '0, '0);
		repeat (20) send_request(F_INSERT, pick_key(), $urandom);
		write_capacity(7'd3);
		run_random(100, 20, 0);
	endtask

	task automatic test_random_mix();
		write_capacity(7'd64);
		run_random(400, 35, 2);
		repeat (3) begin
			write_capacity(CAP_BITS'($urandom_range(127)));
			run_random(200, 35, 3);
		end
	endtask

	// Stall the response side long enough that the input backs up
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_req = 1'b1;
		run_random(60, 40, 2);
		no_idle = 1'b0;
	endtask

	// Response side: random stalls, plus a long hold-off on request
	initial begin : response_sink
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
		end
	end

	// Compare each accepted response against the oldest outstanding outcome
	always @(posedge clk) begin : response_check
		list_outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$error("unexpected response: ok=%0b found_key=%h found_value=%h",
					ok, found_key, found_value);
				error_count++;
			end else begin
				want = outcome_q.pop_front();
				if (ok !== want.ok) begin
					$error("ok mismatch: expected %0b, got %0b", want.ok, ok);
					error_count++;
				end
				if (found_key !== want.fkey) begin
					$error("found_key mismatch: expected %h, got %h", want.fkey, found_key);
					error_count++;
				end
				if (found_value !== want.fval) begin
					$error("found_value mismatch: expected %h, got %h", want.fval, found_value);
					error_count++;
				end
			end
		end
	end

	initial begin : run_limit
		#15ms;
		$display("tb: failure");
		$finish;
	end

	initial begin : main_sequence
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= '0;
		key <= '0;
		value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		error_count = 0;
		mirror_count = 0;
		mirror_cursor = 0;
		mirror_capacity = CAP_RESET;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity_zero();
		test_capacity_one();
		test_full_list_walk();
		test_no_idle_stretch();
		test_capacity_shrink();
		test_random_mix();
		test_backpressure();

		// drop valid, collect the last responses, watch for strays
		in_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: bounded_keyed_list_engine.f
rtl/bkle_pkg.sv
rtl/bkle_ctrl.sv
rtl/bkle_dp.sv
rtl/bounded_keyed_list_engine.sv
tb/sv/tb_bounded_keyed_list_engine.sv
